// File: rtl/mrsd_pkg.sv
// Shared types, codes and helpers for the ModRM/SIB operand decoder.
// Used by mrsd_front, mrsd_queue, mrsd_back and the top level.
`default_nettype none

package mrsd_pkg;

	localparam int unsigned MRSD_QUEUE_DEPTH = 2;

	localparam logic [4:0] REG_NONE      = 5'd31;
	localparam logic [4:0] REG_HIGH_BYTE = 5'd16;
	localparam logic [2:0] SEG_DS        = 3'd3;
	localparam logic [2:0] SEG_LAST      = 3'd5;
	localparam logic [2:0] AVAIL_MAX     = 3'd5;

	localparam logic [1:0] MOD_NO_DISP = 2'd0;
	localparam logic [1:0] MOD_DISP8   = 2'd1;
	localparam logic [1:0] MOD_DISP32  = 2'd2;
	localparam logic [1:0] MOD_REG     = 2'd3;

	localparam logic [2:0] RM_SIB       = 3'd4;
	localparam logic [2:0] RM_RIP       = 3'd5;
	localparam logic [2:0] SIB_NO_INDEX = 3'd4;
	localparam logic [2:0] SIB_NO_BASE  = 3'd5;

	localparam logic [2:0] DLEN_NONE = 3'd0;
	localparam logic [2:0] DLEN_8    = 3'd1;
	localparam logic [2:0] DLEN_32   = 3'd4;

	typedef enum logic [1:0] {
		RM_KIND_REG = 2'd0,
		RM_KIND_MEM = 2'd1,
		RM_KIND_RIP = 2'd2
	} rm_kind_t;

	// Classified operand, handed from the front to the back through the queue.
	typedef struct packed {
		logic        sib_fail;
		rm_kind_t    kind;
		logic [4:0]  base;
		logic [4:0]  index;
		logic [3:0]  scale;
		logic [2:0]  oseg;
		logic        sib_used;
		logic [2:0]  disp_len;
		logic [2:0]  avail;
		logic [31:0] window;
		logic [4:0]  reg_field;
	} mrsd_item_t;

	// Register number from a 3-bit field; high-byte registers map to 16..19.
	function automatic logic [4:0] reg_from_field(input logic [2:0] field,
			input logic ext, input logic byte_hi);
		logic [4:0] r;
		if (byte_hi && field[2]) begin
			r = REG_HIGH_BYTE + {3'b000, field[1:0]};
		end else begin
			r = {1'b0, ext, field};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mrsd_front.sv
// Front part: classifies ModRM, REX, SIB and segment into a queue item.
// Depends on mrsd_pkg.
`default_nettype none

module mrsd_front (
	input  wire logic [7:0]          modrm_byte,
	input  wire logic                has_rex,
	input  wire logic                rex_r,
	input  wire logic                rex_x,
	input  wire logic                rex_b,
	input  wire logic                has_segment_override,
	input  wire logic [2:0]          segment_override,
	input  wire logic [3:0]          operand_size,
	input  wire logic [39:0]         following_bytes,
	input  wire logic [2:0]          bytes_available,
	output mrsd_pkg::mrsd_item_t     item
);
	import mrsd_pkg::*;

	logic [1:0] mod_f;
	logic [2:0] reg_f;
	logic [2:0] rm_f;
	logic       byte_hi;
	logic [7:0] sib;

	assign mod_f   = modrm_byte[7:6];
	assign reg_f   = modrm_byte[5:3];
	assign rm_f    = modrm_byte[2:0];
	assign byte_hi = (operand_size == 4'd1) && !has_rex;
	assign sib     = following_bytes[7:0];

	always_comb begin
		item           = '0;
		item.kind      = RM_KIND_REG;
		item.base      = REG_NONE;
		item.index     = REG_NONE;
		item.disp_len  = DLEN_NONE;
		item.avail     = (bytes_available > AVAIL_MAX) ? AVAIL_MAX : bytes_available;
		item.reg_field = reg_from_field(reg_f, rex_r, byte_hi);

		if (mod_f == MOD_REG) begin
			item.base = reg_from_field(rm_f, rex_b, byte_hi);
		end else begin
			item.oseg = (has_segment_override && segment_override <= SEG_LAST) ?
				segment_override : SEG_DS;
			if (mod_f == MOD_NO_DISP && rm_f == RM_RIP) begin
				item.kind     = RM_KIND_RIP;
				item.disp_len = DLEN_32;
			end else begin
				item.kind = RM_KIND_MEM;
				if (rm_f == RM_SIB) begin
					if (item.avail == 3'd0) begin
						item.sib_fail = 1'b1;
					end else begin
						item.sib_used = 1'b1;
						item.scale    = 4'b0001 << sib[7:6];
						item.index    = (sib[5:3] == SIB_NO_INDEX && !rex_x) ?
							REG_NONE : {1'b0, rex_x, sib[5:3]};
						if (sib[2:0] == SIB_NO_BASE && mod_f == MOD_NO_DISP) begin
							item.disp_len = DLEN_32;
						end else begin
							item.base = {1'b0, rex_b, sib[2:0]};
						end
					end
				end else begin
					item.base = {1'b0, rex_b, rm_f};
				end
				if (mod_f == MOD_DISP8) begin
					item.disp_len = DLEN_8;
				end else if (mod_f == MOD_DISP32) begin
					item.disp_len = DLEN_32;
				end
			end
		end

		// Displacement starts right after the SIB byte when there is one.
		item.window = item.sib_used ? following_bytes[39:8] : following_bytes[31:0];
	end

endmodule

`default_nettype wire

// File: rtl/mrsd_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on mrsd_pkg.
`default_nettype none

module mrsd_queue #(
	parameter int unsigned DEPTH = mrsd_pkg::MRSD_QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output logic                     push_stall,
	input  wire mrsd_pkg::mrsd_item_t push_item,
	output logic                     pop_valid,
	input  wire logic                pop_take,
	output mrsd_pkg::mrsd_item_t     pop_item
);
	import mrsd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	mrsd_item_t       entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_stall = (count_q == CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && pop_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count exceeds depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// File: rtl/mrsd_back.sv
// Back part: reads the displacement, checks byte count, registers the result.
// Depends on mrsd_pkg.
`default_nettype none

module mrsd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_take,
	input  wire mrsd_pkg::mrsd_item_t item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     status,
	output logic [1:0]               rm_kind,
	output logic [4:0]               base_register,
	output logic [4:0]               index_register,
	output logic [3:0]               scale_factor,
	output logic signed [31:0]       displacement,
	output logic [2:0]               operand_segment,
	output logic [2:0]               bytes_used,
	output logic [4:0]               reg_field_register
);
	import mrsd_pkg::*;

	logic        out_valid_q;
	logic        status_q;
	rm_kind_t    kind_q;
	logic [4:0]  base_q;
	logic [4:0]  index_q;
	logic [3:0]  scale_q;
	logic [31:0] disp_q;
	logic [2:0]  oseg_q;
	logic [2:0]  used_q;
	logic [4:0]  reg_q;

	logic [3:0]  need;
	logic        fail;
	logic [31:0] disp;

	assign item_take = item_valid && (!out_valid_q || !out_stall);

	always_comb begin
		need = {3'b000, item.sib_used} + {1'b0, item.disp_len};
		fail = item.sib_fail ||
			((item.disp_len != DLEN_NONE) && (need > {1'b0, item.avail}));
		case (item.disp_len)
			DLEN_8:  disp = {{24{item.window[7]}}, item.window[7:0]};
			DLEN_32: disp = item.window;
			default: disp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			reg_q <= item.reg_field;
			if (fail) begin
				status_q <= 1'b1;
				kind_q   <= RM_KIND_REG;
				base_q   <= REG_NONE;
				index_q  <= REG_NONE;
				scale_q  <= '0;
				disp_q   <= '0;
				oseg_q   <= '0;
				used_q   <= '0;
			end else begin
				status_q <= 1'b0;
				kind_q   <= item.kind;
				base_q   <= item.base;
				index_q  <= item.index;
				scale_q  <= item.scale;
				disp_q   <= disp;
				oseg_q   <= item.oseg;
				used_q   <= need[2:0];
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign rm_kind            = kind_q;
	assign base_register      = base_q;
	assign index_register     = index_q;
	assign scale_factor       = scale_q;
	assign displacement       = disp_q;
	assign operand_segment    = oseg_q;
	assign bytes_used         = used_q;
	assign reg_field_register = reg_q;

	a_fail_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (kind_q == RM_KIND_REG && used_q == 3'd0 &&
			base_q == REG_NONE && disp_q == 32'd0))
		else $error("out-of-bytes result not cleared");

	a_reg_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == RM_KIND_REG) |-> (used_q == 3'd0 && scale_q == 4'd0))
		else $error("register operand consumed bytes");

	a_rip_disp32: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == RM_KIND_RIP) |-> (used_q == 3'd4 && !status_q))
		else $error("RIP-relative operand without disp32");

endmodule

`default_nettype wire

// File: rtl/x86_modrm_sib_operand_decode.sv
// Top level of the ModRM/SIB operand decoder: front, queue and back.
// Depends on mrsd_pkg, mrsd_front, mrsd_queue and mrsd_back.
`default_nettype none

// Decodes one ModRM operand descriptor per clock while neither stall holds
// the flow. An input beat is classified combinationally and written into a
// small queue (QUEUE_DEPTH entries) when it is accepted; the back then reads
// the head item's displacement window into the output register, which drives
// the outputs. Results follow back to back at one per cycle while out_stall
// is low. in_stall rises only when the queue is full, so input beats keep
// flowing while one result waits on out_stall. There is no configuration and
// no state beyond the queue and the output register.
module x86_modrm_sib_operand_decode #(
	parameter int unsigned QUEUE_DEPTH = mrsd_pkg::MRSD_QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   modrm_byte,
	input  wire logic         has_rex,
	input  wire logic         rex_r,
	input  wire logic         rex_x,
	input  wire logic         rex_b,
	input  wire logic         has_segment_override,
	input  wire logic [2:0]   segment_override,
	input  wire logic [3:0]   operand_size,
	input  wire logic [39:0]  following_bytes,
	input  wire logic [2:0]   bytes_available,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic              status,
	output logic [1:0]        rm_kind,
	output logic [4:0]        base_register,
	output logic [4:0]        index_register,
	output logic [3:0]        scale_factor,
	output logic signed [31:0] displacement,
	output logic [2:0]        operand_segment,
	output logic [2:0]        bytes_used,
	output logic [4:0]        reg_field_register
);
	import mrsd_pkg::*;

	mrsd_item_t front_item;
	mrsd_item_t queue_item;
	logic       queue_valid;
	logic       queue_take;

	mrsd_front u_front (
		.modrm_byte           (modrm_byte),
		.has_rex              (has_rex),
		.rex_r                (rex_r),
		.rex_x                (rex_x),
		.rex_b                (rex_b),
		.has_segment_override (has_segment_override),
		.segment_override     (segment_override),
		.operand_size         (operand_size),
		.following_bytes      (following_bytes),
		.bytes_available      (bytes_available),
		.item                 (front_item)
	);

	mrsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_stall (in_stall),
		.push_item  (front_item),
		.pop_valid  (queue_valid),
		.pop_take   (queue_take),
		.pop_item   (queue_item)
	);

	mrsd_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_valid         (queue_valid),
		.item_take          (queue_take),
		.item               (queue_item),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.rm_kind            (rm_kind),
		.base_register      (base_register),
		.index_register     (index_register),
		.scale_factor       (scale_factor),
		.displacement       (displacement),
		.operand_segment    (operand_segment),
		.bytes_used         (bytes_used),
		.reg_field_register (reg_field_register)
	);

endmodule

`default_nettype wire
